[rtl/emboss_filter_3x3_unit_macros.svh]
// Assertion macros shared by the checker of the emboss filter.
`ifndef EMBOSS_FILTER_3X3_UNIT_MACROS_SVH
`define EMBOSS_FILTER_3X3_UNIT_MACROS_SVH

// Checked only while the block is out of reset.
`define EF3_ASSERT_RUN(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Checked at every edge, reset included.
`define EF3_ASSERT_ANY(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[rtl/ef3_pkg.sv]
`timescale 1ns / 1ps

package ef3_pkg;

    localparam int unsigned DEF_MAX_WIDTH  = 1024;
    localparam int unsigned DEF_MAX_HEIGHT = 1024;
    localparam int unsigned CFG_W          = 11;
    localparam int unsigned CFG_IDX_W      = 1;
    localparam int unsigned CFG_RESET      = 1024;
    localparam int unsigned MIN_SIZE       = 3;
    localparam int unsigned PIX_W          = 8;
    localparam int unsigned COORD_W        = 10;
    localparam int unsigned IN_DATA_W      = 32;
    localparam int unsigned OUT_DATA_W     = 40;
    localparam int unsigned FIFO_DEPTH     = 4;
    localparam int unsigned FIFO_CNT_W     = $clog2(FIFO_DEPTH + 1);
    localparam int unsigned GRAY_RECIP     = 683;
    localparam int unsigned GRAY_SHIFT     = 11;
    localparam int unsigned LEVEL_OFFSET   = 128;
    localparam int unsigned LEVEL_MAX      = 255;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic               frame_done;
        logic [PIX_W-1:0]   out_alpha;
        logic [PIX_W-1:0]   level;
        logic [COORD_W-1:0] out_row;
        logic [COORD_W-1:0] out_col;
    } t_result;

endpackage

[rtl/emboss_filter_3x3_unit.sv]
`timescale 1ns / 1ps
// Diagonal 3x3 emboss on an RGBA pixel stream in raster order.
// Input channel s_axis: one pixel per request, tuser marks the first pixel of a frame.
// Output channel m_axis: one result per interior centre pixel, tlast marks the last
// interior result of the frame. Border pixels cause no result.
// Configuration: i_cfg_we writes i_cfg_wdata to register i_cfg_index
// (0 image width, 1 image height); values are clamped to 3..MAX_WIDTH or MAX_HEIGHT.
// Throughput is one pixel per clock while s_axis_tready is high. Both line-memory reads
// of a pixel are issued in the cycle it is accepted and its gray value is written back
// from stage 2, so the single line memory with two read ports and one write port sets that rate.
// A result passes the stage-1 and stage-2 registers and the output queue before it is presented.
// When the receiver stalls, results collect in a four-entry output queue; s_axis_tready
// falls only when the queue and the two pipeline stages together could overflow it.
// Reset clears the position counters, the pipeline and the queue and sets both sizes to
// 1024 (or the maximum). The line memory is not cleared; only entries that were written
// earlier within the frame feed an emitted result.
module emboss_filter_3x3_unit
    import ef3_pkg::*;
#(
    parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_W-1:0]      i_cfg_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // red, green, blue, alpha
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // start_of_frame
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // out_col, out_row, level, out_alpha, zero fill
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tlast
);

    localparam int unsigned XW    = $clog2(MAX_WIDTH);
    localparam int unsigned YW    = $clog2(MAX_HEIGHT);
    localparam int unsigned SW    = $clog2(MAX_WIDTH + 1);
    localparam int unsigned SH    = $clog2(MAX_HEIGHT + 1);
    localparam int unsigned DEPTH = 2 * MAX_WIDTH;
    localparam int unsigned AW    = $clog2(DEPTH);
    localparam int unsigned RST_W = (CFG_RESET > MAX_WIDTH) ? MAX_WIDTH : CFG_RESET;
    localparam int unsigned RST_H = (CFG_RESET > MAX_HEIGHT) ? MAX_HEIGHT : CFG_RESET;

    logic [SW-1:0] r_width;
    logic [SH-1:0] r_height;
    logic [XW-1:0] r_col;
    logic [YW-1:0] r_row;

    logic [31:0]   cfg_ext;
    logic [31:0]   cfg_w_clamped;
    logic [31:0]   cfg_h_clamped;

    logic          acc;
    logic [XW:0]   col_s;
    logic [YW:0]   row_s;
    logic [XW-1:0] x;
    logic [YW-1:0] y;
    logic [XW-1:0] x_m1;
    logic [XW:0]   col_n;
    logic [YW:0]   row_n;
    logic [AW-1:0] here_addr;
    logic [AW-1:0] prev_addr;

    logic [PIX_W-1:0] r_gray_lines [DEPTH];
    logic [PIX_W-1:0] r_two_up;
    logic [PIX_W-1:0] r_diag;
    logic [PIX_W-1:0] r_up_near;
    logic [PIX_W-1:0] r_up_far;

    logic               r1_v;
    logic [9:0]         r1_sum;
    logic [PIX_W-1:0]   r1_alpha;
    logic [COORD_W-1:0] r1_col;
    logic [COORD_W-1:0] r1_row;
    logic               r1_emit;
    logic               r1_last;
    logic [AW-1:0]      r1_addr;
    logic [19:0]        gray_prod;

    logic               r2_v;
    logic [PIX_W-1:0]   r2_a;
    logic [PIX_W-1:0]   r2_b;
    logic [PIX_W-1:0]   r2_gray;
    logic [PIX_W-1:0]   r2_alpha;
    logic [COORD_W-1:0] r2_col;
    logic [COORD_W-1:0] r2_row;
    logic               r2_emit;
    logic               r2_last;
    logic [AW-1:0]      r2_addr;

    logic [11:0]        pos_part;
    logic [11:0]        neg_part;
    logic [11:0]        diff;
    logic [PIX_W-1:0]   level;

    t_result               push_data;
    t_result               head;
    logic [FIFO_CNT_W-1:0] fifo_count;
    logic [FIFO_CNT_W+1:0] committed;

    assign cfg_ext       = 32'(i_cfg_wdata);
    assign cfg_w_clamped = (cfg_ext < MIN_SIZE) ? MIN_SIZE :
                           (cfg_ext > MAX_WIDTH) ? MAX_WIDTH : cfg_ext;
    assign cfg_h_clamped = (cfg_ext < MIN_SIZE) ? MIN_SIZE :
                           (cfg_ext > MAX_HEIGHT) ? MAX_HEIGHT : cfg_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= SW'(RST_W);
            r_height <= SH'(RST_H);
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_IMAGE_WIDTH:  r_width  <= SW'(cfg_w_clamped);
                REG_IMAGE_HEIGHT: r_height <= SH'(cfg_h_clamped);
                default: ;
            endcase
        end
    end

    assign committed     = (FIFO_CNT_W+2)'(fifo_count) + (FIFO_CNT_W+2)'(r1_v)
                         + (FIFO_CNT_W+2)'(r2_v);
    assign s_axis_tready = (32'(committed) < FIFO_DEPTH);
    assign acc           = s_axis_tvalid && s_axis_tready;

    always_comb begin
        col_s = s_axis_tuser ? '0 : {1'b0, r_col};
        row_s = s_axis_tuser ? '0 : {1'b0, r_row};
        if (col_s >= (XW+1)'(r_width)) begin
            col_s = '0;
            row_s = row_s + 1'b1;
        end
        if (row_s >= (YW+1)'(r_height)) begin
            row_s = '0;
        end
        x = col_s[XW-1:0];
        y = row_s[YW-1:0];

        col_n = {1'b0, x} + 1'b1;
        row_n = {1'b0, y};
        if (col_n >= (XW+1)'(r_width)) begin
            col_n = '0;
            row_n = {1'b0, y} + 1'b1;
            if (row_n >= (YW+1)'(r_height)) begin
                row_n = '0;
            end
        end

        x_m1      = (x == '0) ? '0 : x - 1'b1;
        here_addr = (y[0] ? AW'(MAX_WIDTH) : '0) + AW'(x);
        prev_addr = (y[0] ? '0 : AW'(MAX_WIDTH)) + AW'(x_m1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (acc) begin
            r_col <= col_n[XW-1:0];
            r_row <= row_n[YW-1:0];
        end
    end

    // Row y-2 at the same column is read before the gray value of row y replaces it.
    // The diagonal entry of row y-1 was written at least one line earlier.
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_two_up <= r_gray_lines[here_addr];
            r_diag   <= r_gray_lines[prev_addr];
        end
        if (r2_v) begin
            r_gray_lines[r2_addr] <= r2_gray;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v      <= 1'b0;
            r2_v      <= 1'b0;
            r_up_near <= '0;
            r_up_far  <= '0;
        end else begin
            r1_v <= acc;
            r2_v <= r1_v;
            if (r1_v) begin
                r_up_near <= r_two_up;
                r_up_far  <= r_up_near;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r1_sum   <= 10'(s_axis_tdata[7:0]) + 10'(s_axis_tdata[15:8])
                      + 10'(s_axis_tdata[23:16]);
            r1_alpha <= s_axis_tdata[31:24];
            r1_col   <= COORD_W'(32'(x) - 32'd1);
            r1_row   <= COORD_W'(32'(y) - 32'd1);
            r1_emit  <= (32'(x) >= 32'd2) && (32'(y) >= 32'd2);
            r1_last  <= ((XW+1)'(x) == (XW+1)'(r_width) - 1'b1)
                     && ((YW+1)'(y) == (YW+1)'(r_height) - 1'b1);
            r1_addr  <= here_addr;
        end
    end

    assign gray_prod = 20'(r1_sum) * 20'(GRAY_RECIP);

    always_ff @(posedge i_clk) begin
        if (r1_v) begin
            r2_a     <= r_up_far;
            r2_b     <= r_diag;
            r2_gray  <= gray_prod[GRAY_SHIFT+PIX_W-1:GRAY_SHIFT];
            r2_alpha <= r1_alpha;
            r2_col   <= r1_col;
            r2_row   <= r1_row;
            r2_emit  <= r1_emit;
            r2_last  <= r1_last;
            r2_addr  <= r1_addr;
        end
    end

    always_comb begin
        pos_part = {3'b000, r2_a, 1'b0} + 12'(LEVEL_OFFSET);
        neg_part = 12'(r2_b) + 12'(r2_gray);
        diff     = pos_part - neg_part;
        if (pos_part < neg_part) begin
            level = '0;
        end else if (32'(diff) > LEVEL_MAX) begin
            level = PIX_W'(LEVEL_MAX);
        end else begin
            level = diff[PIX_W-1:0];
        end
        push_data.out_col    = r2_col;
        push_data.out_row    = r2_row;
        push_data.level      = level;
        push_data.out_alpha  = r2_alpha;
        push_data.frame_done = r2_last;
    end

    ef3_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r2_v && r2_emit),
        .i_data  (push_data),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (head),
        .o_count (fifo_count)
    );

    assign m_axis_tdata = {4'b0000, head.out_alpha, head.level, head.out_row, head.out_col};
    assign m_axis_tlast = head.frame_done;

endmodule

[rtl/ef3_out_fifo.sv]
`timescale 1ns / 1ps

module ef3_out_fifo
    import ef3_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  t_result               i_data,
    output logic                  o_valid,
    input  logic                  i_ready,
    output t_result               o_data,
    output logic [FIFO_CNT_W-1:0] o_count
);

    localparam int unsigned PW = $clog2(FIFO_DEPTH);

    t_result               r_data [FIFO_DEPTH];
    logic [PW-1:0]         r_wr;
    logic [PW-1:0]         r_rd;
    logic [FIFO_CNT_W-1:0] r_count;
    logic [FIFO_CNT_W-1:0] n_count;
    logic                  pop;

    assign o_valid = (r_count != '0);
    assign o_data  = r_data[r_rd];
    assign o_count = r_count;
    assign pop     = o_valid && i_ready;

    always_comb begin
        n_count = r_count;
        if (i_push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr <= (32'(r_wr) == FIFO_DEPTH - 1) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (32'(r_rd) == FIFO_DEPTH - 1) ? '0 : r_rd + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data[r_wr] <= i_data;
        end
    end

endmodule

[rtl/ef3_checker.sv]
`timescale 1ns / 1ps
`include "emboss_filter_3x3_unit_macros.svh"

module ef3_checker
    import ef3_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic                  m_axis_tlast
);

    `EF3_ASSERT_RUN(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "Stalled result changed or vanished.")
    `EF3_ASSERT_ANY(a_out_empty_after_reset, !i_rst_n |=> !m_axis_tvalid, "Result pending right after reset.")
    `EF3_ASSERT_ANY(a_ready_after_reset, !i_rst_n |=> s_axis_tready, "Input not ready right after reset.")
    `EF3_ASSERT_RUN(a_interior_only, m_axis_tvalid |-> m_axis_tdata[9:0] != 10'd0 && m_axis_tdata[19:10] != 10'd0, "Result on a border pixel.")

endmodule

bind emboss_filter_3x3_unit ef3_checker u_ef3_checker (.*);
